// File: rtl/core/glos_pkg.sv
// shared types and constants of the grid line-of-sight unit
`default_nettype none

package glos_pkg;

  localparam int KIND_W    = 2;
  localparam int COORD_W   = 8;
  localparam int ALPHA_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CELL_W    = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STRICT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELAXED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0]   SIZE_RESET  = 9'd256;
  localparam logic [ALPHA_W-1:0] SOLID_LIMIT = 8'd128;

  // bit positions inside a stored cell
  localparam int CELL_SOLID   = 0;
  localparam int CELL_VISITED = 1;

  typedef logic [COORD_W-1:0] coord_t;

endpackage

`default_nettype wire

// File: rtl/core/glos_if.sv
// request and result channel interfaces of the grid line-of-sight unit
`default_nettype none

interface glos_req_if
  import glos_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  coord_t              cell_x;
  coord_t              cell_y;
  logic [ALPHA_W-1:0]  cell_alpha;
  logic                cell_visited;
  coord_t              from_x;
  coord_t              from_y;
  coord_t              to_x;
  coord_t              to_y;

  modport source (
    output valid, kind, cell_x, cell_y, cell_alpha, cell_visited,
           from_x, from_y, to_x, to_y,
    input  ready
  );
  modport sink (
    input  valid, kind, cell_x, cell_y, cell_alpha, cell_visited,
           from_x, from_y, to_x, to_y,
    output ready
  );
endinterface

interface glos_res_if;
  logic valid;
  logic ready;
  logic path_clear;
  logic range_error;

  modport source (output valid, path_clear, range_error, input ready);
  modport sink   (input valid, path_clear, range_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/glos_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module glos_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/grid_line_of_sight_unit.sv
// grid line-of-sight unit: cell store and stepping line tracer
//
//   port        dir  role
//   in_req      in   cell write or line query request
//   out_res     out  path_clear and range_error per request
//   cfg_*       in   grid_width / grid_height register writes
//
// a write, an ignored request and an out-of-grid query go straight to the done state
// a query reads the ram once per traced cell; in relaxed mode each solid
// cell adds up to 4 more reads, one per in-grid neighbour, from the single ram port
// in_req.ready is high only while idle; a finished result waits in the output
// register, so the next request can be taken while out_res is stalled
// synchronous active-low reset clears control and loads 256 into the size registers only;
// the cell store is not cleared
`default_nettype none

module grid_line_of_sight_unit
  import glos_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  glos_req_if.sink                  in_req,
  glos_res_if.source                out_res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int EH    = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CELL = 2'd1;
  localparam logic [1:0] ST_NB   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [AW-1:0] cell_addr(input coord_t x, input coord_t y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  logic [CFG_W-1:0] grid_w_r, grid_h_r;
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;

  logic [1:0]   state_r, state_nxt;
  coord_t       px_r, px_nxt, py_r, py_nxt;
  coord_t       major_r, major_nxt, minor_r, minor_nxt, cnt_r, cnt_nxt;
  logic [8:0]   err_r, err_nxt;
  logic         xmaj_r, xmaj_nxt, sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic         relaxed_r, relaxed_nxt;
  logic [1:0]   nb_r, nb_nxt;
  logic         res_clear_r, res_clear_nxt, res_range_r, res_range_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_clear_r, out_clear_nxt, out_range_r, out_range_nxt;

  logic              in_fire;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic         cell_oob, query_oob;
  coord_t       ax, ay;
  logic [8:0]   e_sum, err_step;
  logic         step_minor;
  coord_t       step_x, step_y;
  logic [3:0]   nb_ok;
  logic [2:0]   nb_from;
  logic [1:0]   nb_sel;
  logic         nb_any;
  logic [AW-1:0] nb_addr;

  // size registers clamped to the supported range
  always_comb begin
    if (grid_w_r == '0) begin
      eff_w = EW'(1);
    end else if (EW'(grid_w_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(grid_w_r);
    end
    if (grid_h_r == '0) begin
      eff_h = EH'(1);
    end else if (EH'(grid_h_r) > EH'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(grid_h_r);
    end
  end

  assign in_fire    = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  assign cell_oob  = (EW'(in_req.cell_x) >= eff_w) || (EH'(in_req.cell_y) >= eff_h);
  assign query_oob = (EW'(in_req.from_x) >= eff_w) || (EH'(in_req.from_y) >= eff_h) ||
                     (EW'(in_req.to_x) >= eff_w)   || (EH'(in_req.to_y) >= eff_h);

  assign ax = (in_req.to_x >= in_req.from_x) ? in_req.to_x - in_req.from_x
                                             : in_req.from_x - in_req.to_x;
  assign ay = (in_req.to_y >= in_req.from_y) ? in_req.to_y - in_req.from_y
                                             : in_req.from_y - in_req.to_y;

  assign ram_waddr = cell_addr(in_req.cell_x, in_req.cell_y);
  assign ram_wdata = {in_req.cell_visited, (in_req.cell_alpha < SOLID_LIMIT)};

  // one bresenham step along the major axis
  assign e_sum      = err_r + {1'b0, minor_r};
  assign step_minor = (e_sum >= {1'b0, major_r});
  assign err_step   = step_minor ? e_sum - {1'b0, major_r} : e_sum;

  always_comb begin
    step_x = px_r;
    step_y = py_r;
    if (xmaj_r) begin
      step_x = sx_neg_r ? px_r - 8'd1 : px_r + 8'd1;
      if (step_minor) begin
        step_y = sy_neg_r ? py_r - 8'd1 : py_r + 8'd1;
      end
    end else begin
      step_y = sy_neg_r ? py_r - 8'd1 : py_r + 8'd1;
      if (step_minor) begin
        step_x = sx_neg_r ? px_r - 8'd1 : px_r + 8'd1;
      end
    end
  end

  // neighbour order: left, right, up, down; in-grid ones only
  assign nb_ok[0] = (px_r != '0);
  assign nb_ok[1] = ((EW'(px_r) + EW'(1)) < eff_w);
  assign nb_ok[2] = (py_r != '0);
  assign nb_ok[3] = ((EH'(py_r) + EH'(1)) < eff_h);
  assign nb_from  = (state_r == ST_NB) ? {1'b0, nb_r} + 3'd1 : 3'd0;

  always_comb begin
    nb_sel = 2'd0;
    nb_any = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (nb_ok[i] && (3'(i) >= nb_from)) begin
        nb_sel = 2'(i);
        nb_any = 1'b1;
      end
    end
  end

  always_comb begin
    case (nb_sel)
      2'd0:    nb_addr = cell_addr(px_r - 8'd1, py_r);
      2'd1:    nb_addr = cell_addr(px_r + 8'd1, py_r);
      2'd2:    nb_addr = cell_addr(px_r, py_r - 8'd1);
      default: nb_addr = cell_addr(px_r, py_r + 8'd1);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    xmaj_nxt      = xmaj_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    relaxed_nxt   = relaxed_r;
    nb_nxt        = nb_r;
    res_clear_nxt = res_clear_r;
    res_range_nxt = res_range_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_clear_nxt = out_clear_r;
    out_range_nxt = out_range_r;
    ram_we        = 1'b0;
    ram_raddr     = cell_addr(px_r, py_r);

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = cell_addr(in_req.from_x, in_req.from_y);
        if (in_fire) begin
          res_clear_nxt = 1'b0;
          res_range_nxt = 1'b0;
          state_nxt     = ST_DONE;
          case (in_req.kind) inside
            KIND_WRITE: begin
              res_range_nxt = cell_oob;
              ram_we        = !cell_oob;
            end
            KIND_STRICT, KIND_RELAXED: begin
              relaxed_nxt = (in_req.kind == KIND_RELAXED);
              if (query_oob) begin
                res_range_nxt = 1'b1;
              end else begin
                px_nxt     = in_req.from_x;
                py_nxt     = in_req.from_y;
                sx_neg_nxt = (in_req.to_x < in_req.from_x);
                sy_neg_nxt = (in_req.to_y < in_req.from_y);
                xmaj_nxt   = (ax >= ay);
                major_nxt  = (ax >= ay) ? ax : ay;
                minor_nxt  = (ax >= ay) ? ay : ax;
                cnt_nxt    = (ax >= ay) ? ax : ay;
                err_nxt    = {2'b00, ((ax >= ay) ? ax[7:1] : ay[7:1])};
                state_nxt  = ST_CELL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CELL, ST_NB: begin
        if ((state_r == ST_CELL && !ram_rdata[CELL_SOLID]) ||
            (state_r == ST_NB && ram_rdata[CELL_VISITED])) begin
          // cell passes: finish or move to the next one
          if (cnt_r == '0) begin
            res_clear_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            px_nxt    = step_x;
            py_nxt    = step_y;
            err_nxt   = err_step;
            cnt_nxt   = cnt_r - 8'd1;
            ram_raddr = cell_addr(step_x, step_y);
            state_nxt = ST_CELL;
          end
        end else if (relaxed_r && nb_any) begin
          nb_nxt    = nb_sel;
          ram_raddr = nb_addr;
          state_nxt = ST_NB;
        end else begin
          res_clear_nxt = 1'b0;
          state_nxt     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_clear_r;
          out_range_nxt = res_range_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      grid_w_r    <= SIZE_RESET;
      grid_h_r    <= SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
          REG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    major_r     <= major_nxt;
    minor_r     <= minor_nxt;
    cnt_r       <= cnt_nxt;
    err_r       <= err_nxt;
    xmaj_r      <= xmaj_nxt;
    sx_neg_r    <= sx_neg_nxt;
    sy_neg_r    <= sy_neg_nxt;
    relaxed_r   <= relaxed_nxt;
    nb_r        <= nb_nxt;
    res_clear_r <= res_clear_nxt;
    res_range_r <= res_range_nxt;
    out_clear_r <= out_clear_nxt;
    out_range_r <= out_range_nxt;
  end

  glos_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_res.valid       = out_valid_r;
  assign out_res.path_clear  = out_clear_r;
  assign out_res.range_error = out_range_r;

endmodule

`default_nettype wire

// File: rtl/core/glos_checker.sv
// port-level assertions for the grid line-of-sight unit, bound to the top level
`default_nettype none

module glos_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_path_clear,
  input wire logic out_range_error
);

  // result register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_path_clear) &&
                                $stable(out_range_error))
    else $error("stalled result changed");

  // a clear path never comes with a range error
  a_clear_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_path_clear && out_range_error))
    else $error("path_clear and range_error both set");

  // one request in flight: busy in the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind grid_line_of_sight_unit glos_checker u_glos_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_path_clear  (out_res.path_clear),
  .out_range_error (out_res.range_error)
);

`default_nettype wire
